@@ hdl/two_tone_wavetable_synth_unit_assert.svh @@
// Assertion macros for the two-tone synthesizer RTL.
`ifndef TWO_TONE_WAVETABLE_SYNTH_UNIT_ASSERT_SVH
`define TWO_TONE_WAVETABLE_SYNTH_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define TTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("two-tone synth: assertion failed");
`define TTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("two-tone synth: assertion failed");
`else
`define TTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/tts_pkg.sv @@
// Types, constants and sine table generator for the two-tone synthesizer.
`default_nettype none

package tts_pkg;

	localparam int VOL_W     = 12;
	localparam int CODE_W    = 12;
	localparam int STEP_W    = 26;
	localparam int SAMPLE_W  = 16;
	localparam int SUM_W     = SAMPLE_W + 1;
	localparam int PROD_W    = SUM_W + VOL_W + 1;
	localparam int CFG_IDX_W = 4;
	localparam int OUT_SHIFT = 17;

	localparam logic [CODE_W-1:0] MID_CODE = CODE_W'(2048);

	localparam logic [CFG_IDX_W-1:0] REG_STEP_A = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_STEP_B = CFG_IDX_W'(1);

	localparam int QUEUE_DEPTH = 4;
	localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

	// Q30 angle constants and Taylor denominators (2k)(2k+1)
	localparam int          Q_BITS       = 30;
	localparam logic [63:0] Q_TWO_PI     = 64'd6746518852;
	localparam logic [63:0] Q_PI         = 64'd3373259426;
	localparam logic [63:0] Q_HALF_PI    = 64'd1686629713;
	localparam logic [63:0] AMPLITUDE    = 64'd32767;
	localparam int          TAYLOR_TERMS = 12;
	localparam logic [63:0] TAYLOR_DEN [TAYLOR_TERMS] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
		64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
	};

	typedef struct packed {
		logic signed [SUM_W-1:0] tone_sum;
		logic [VOL_W-1:0]        volume_level;
	} tts_work_t;

	typedef struct packed {
		logic fill_done;
		logic red_busy;
		logic s1_valid;
	} tts_front_stat_t;

	// Elaboration-time only: sine sample for a Q30 angle in [0, 2*pi)
	function automatic logic signed [SAMPLE_W-1:0] sine_from_angle(input logic [63:0] ang);
		logic [63:0] a;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] acc;
		logic [63:0] mag;
		logic        neg;
		a = ang;
		neg = 1'b0;
		if (a >= Q_PI) begin
			a = a - Q_PI;
			neg = 1'b1;
		end
		if (a > Q_HALF_PI)
			a = Q_PI - a;
		x2 = (a * a) >> Q_BITS;
		term = a;
		acc = a;
		for (int k = 1; k <= TAYLOR_TERMS; k++) begin
			term = ((term * x2) >> Q_BITS) / TAYLOR_DEN[k-1];
			if (k[0])
				acc = (acc >= term) ? acc - term : 64'd0;
			else
				acc = acc + term;
		end
		mag = (AMPLITUDE * acc) >> Q_BITS;
		if (mag > AMPLITUDE)
			mag = AMPLITUDE;
		return neg ? -SAMPLE_W'(mag) : SAMPLE_W'(mag);
	endfunction

endpackage

`default_nettype wire

@@ hdl/tts_in_if.sv @@
// Sample tick channel: one volume level per beat.
`default_nettype none

interface tts_in_if import tts_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [VOL_W-1:0] volume_level;

	modport source (output valid, output volume_level, input ready);
	modport sink (input valid, input volume_level, output ready);
endinterface

`default_nettype wire

@@ hdl/tts_out_if.sv @@
// DAC sample channel: one code per beat.
`default_nettype none

interface tts_out_if import tts_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] dac_code;

	modport source (output valid, output dac_code, input ready);
	modport sink (input valid, input dac_code, output ready);
endinterface

`default_nettype wire

@@ hdl/tts_cfg_if.sv @@
// Register write channel: index and data per beat.
`default_nettype none

interface tts_cfg_if import tts_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [STEP_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/tts_ram.sv @@
// Generic RAM, one write port, two registered read ports.
`default_nettype none

module tts_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end
endmodule

`default_nettype wire

@@ hdl/tts_queue.sv @@
// Small register FIFO between the front and back halves.
`default_nettype none

module tts_queue #(
	parameter int WIDTH = 29,
	parameter int DEPTH = 4
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire logic [WIDTH-1:0]           push_data,
	input  wire logic                       pop,
	output logic      [WIDTH-1:0]           pop_data,
	output logic      [$clog2(DEPTH+1)-1:0] count
);
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign pop_data = entry_q[rd_ptr_q];
	assign count    = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end
endmodule

`default_nettype wire

@@ hdl/tts_front.sv @@
// Front half: table load, step registers, phase accumulators and sine lookup.
`default_nettype none

module tts_front import tts_pkg::*; #(
	parameter int TABLE_SIZE    = 1024,
	parameter int FRACTION_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	tts_in_if.sink                     sample_in,
	tts_cfg_if.sink                    cfg,
	input  wire logic [Q_CNT_W-1:0]    q_count,
	output logic                       push,
	output tts_work_t                  push_data,
	output tts_front_stat_t            stat
);
	localparam int ADDR_W   = $clog2(TABLE_SIZE);
	localparam int PHASE_W  = ADDR_W + FRACTION_BITS;
	localparam int HI_W     = STEP_W - FRACTION_BITS;
	localparam int RECIP_SH = HI_W + ADDR_W;
	localparam int RECIP_W  = HI_W + 2;
	localparam int RPROD_W  = HI_W + RECIP_W;
	localparam logic [PHASE_W:0]  LIMIT     = (PHASE_W + 1)'(TABLE_SIZE) << FRACTION_BITS;
	localparam logic [ADDR_W-1:0] FILL_LAST = ADDR_W'(TABLE_SIZE - 1);
	// floor(hi / TABLE_SIZE) == (hi * RECIP) >> RECIP_SH for every HI_W-bit hi
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
		((64'd1 << RECIP_SH) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE));
	localparam logic [HI_W-1:0]    TABLE_HI = HI_W'(TABLE_SIZE);

	logic signed [SAMPLE_W-1:0] sine_const [TABLE_SIZE];

	for (genvar gi = 0; gi < TABLE_SIZE; gi++) begin : g_sine
		localparam logic [63:0] ANGLE = (64'(gi) * Q_TWO_PI) / 64'(TABLE_SIZE);
		assign sine_const[gi] = sine_from_angle(ANGLE);
	end

	logic [ADDR_W-1:0]   fill_cnt_q;
	logic                fill_done_q;
	logic                fill_wr_s1;
	logic [ADDR_W-1:0]   fill_addr_s1;
	logic [SAMPLE_W-1:0] fill_data_s1;

	logic [PHASE_W-1:0] step_a_q;
	logic [PHASE_W-1:0] step_b_q;
	logic [PHASE_W-1:0] phase_a_q;
	logic [PHASE_W-1:0] phase_b_q;

	logic               red_busy_q;
	logic               red_chan_b_q;
	logic               red_stage_q;
	logic [STEP_W-1:0]  red_rem_q;
	logic [HI_W-1:0]    red_quot_q;
	logic [RPROD_W-1:0] red_prod;
	logic [HI_W-1:0]    red_rem_hi;
	logic [PHASE_W-1:0] red_step;

	logic [PHASE_W:0]   sum_a;
	logic [PHASE_W:0]   sum_b;
	logic [PHASE_W-1:0] phase_a_nxt;
	logic [PHASE_W-1:0] phase_b_nxt;

	logic                valid_s1;
	logic [VOL_W-1:0]    vol_s1;
	logic [SAMPLE_W-1:0] rdata_a;
	logic [SAMPLE_W-1:0] rdata_b;

	logic             in_ok;
	logic             in_acc;
	logic             cfg_acc;
	logic [Q_CNT_W:0] inflight;

	// step is reduced modulo the period: reciprocal quotient, then remainder
	assign red_prod   = RPROD_W'(red_rem_q[STEP_W-1 -: HI_W]) * RPROD_W'(RECIP);
	assign red_rem_hi = red_rem_q[STEP_W-1 -: HI_W] - red_quot_q * TABLE_HI;
	assign red_step   = PHASE_W'({red_rem_hi, red_rem_q[FRACTION_BITS-1:0]});

	always_comb begin
		sum_a = (PHASE_W + 1)'(phase_a_q) + (PHASE_W + 1)'(step_a_q);
		sum_b = (PHASE_W + 1)'(phase_b_q) + (PHASE_W + 1)'(step_b_q);
		phase_a_nxt = (sum_a >= LIMIT) ? PHASE_W'(sum_a - LIMIT) : PHASE_W'(sum_a);
		phase_b_nxt = (sum_b >= LIMIT) ? PHASE_W'(sum_b - LIMIT) : PHASE_W'(sum_b);
	end

	// a pending register write goes first
	assign inflight = (Q_CNT_W + 1)'(q_count) + (Q_CNT_W + 1)'(valid_s1);
	assign in_ok    = fill_done_q && !fill_wr_s1 && !red_busy_q && !cfg.valid &&
		(inflight < (Q_CNT_W + 1)'(QUEUE_DEPTH));
	assign in_acc   = sample_in.valid && in_ok;
	assign cfg_acc  = cfg.valid && !red_busy_q;

	assign sample_in.ready = in_ok;
	assign cfg.ready       = !red_busy_q;

	tts_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (TABLE_SIZE)
	) u_sine_ram (
		.clk     (clk),
		.we      (fill_wr_s1),
		.waddr   (fill_addr_s1),
		.wdata   (fill_data_s1),
		.raddr_a (phase_a_nxt[PHASE_W-1 -: ADDR_W]),
		.raddr_b (phase_b_nxt[PHASE_W-1 -: ADDR_W]),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_cnt_q   <= '0;
			fill_done_q  <= 1'b0;
			fill_wr_s1   <= 1'b0;
			step_a_q     <= '0;
			step_b_q     <= '0;
			phase_a_q    <= '0;
			phase_b_q    <= '0;
			red_busy_q   <= 1'b0;
			red_chan_b_q <= 1'b0;
			red_stage_q  <= 1'b0;
			valid_s1     <= 1'b0;
		end else begin
			fill_wr_s1 <= !fill_done_q;
			if (!fill_done_q) begin
				if (fill_cnt_q == FILL_LAST)
					fill_done_q <= 1'b1;
				else
					fill_cnt_q <= fill_cnt_q + ADDR_W'(1);
			end

			valid_s1 <= in_acc;
			if (in_acc) begin
				phase_a_q <= phase_a_nxt;
				phase_b_q <= phase_b_nxt;
			end

			if (red_busy_q) begin
				red_stage_q <= 1'b0;
				if (!red_stage_q) begin
					red_busy_q <= 1'b0;
					if (red_chan_b_q)
						step_b_q <= red_step;
					else
						step_a_q <= red_step;
				end
			end

			if (cfg_acc) begin
				case (cfg.index)
					REG_STEP_A: begin
						red_busy_q   <= 1'b1;
						red_chan_b_q <= 1'b0;
						red_stage_q  <= 1'b1;
						if (cfg.data == '0)
							phase_a_q <= '0;
					end
					REG_STEP_B: begin
						red_busy_q   <= 1'b1;
						red_chan_b_q <= 1'b1;
						red_stage_q  <= 1'b1;
						if (cfg.data == '0)
							phase_b_q <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		fill_addr_s1 <= fill_cnt_q;
		fill_data_s1 <= sine_const[fill_cnt_q];
		if (in_acc)
			vol_s1 <= sample_in.volume_level;
		if (cfg_acc)
			red_rem_q <= cfg.data;
		if (red_busy_q && red_stage_q)
			red_quot_q <= HI_W'(red_prod >> RECIP_SH);
	end

	assign push                   = valid_s1;
	assign push_data.tone_sum     = SUM_W'($signed(rdata_a)) + SUM_W'($signed(rdata_b));
	assign push_data.volume_level = vol_s1;

	assign stat.fill_done = fill_done_q && !fill_wr_s1;
	assign stat.red_busy  = red_busy_q;
	assign stat.s1_valid  = valid_s1;
endmodule

`default_nettype wire

@@ hdl/tts_back.sv @@
// Back half: volume multiply, floor shift, offset to DAC code, output register.
`default_nettype none

module tts_back import tts_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [Q_CNT_W-1:0] q_count,
	input  wire tts_work_t          q_data,
	output logic                    pop,
	tts_out_if.source               sample_out
);
	logic                     prod_valid_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [PROD_W-1:0] scaled;
	logic                     out_valid_q;
	logic [CODE_W-1:0]        dac_q;
	logic                     out_free;
	logic                     prod_adv;

	assign out_free = !out_valid_q || sample_out.ready;
	assign prod_adv = !prod_valid_s2 || out_free;
	assign pop      = (q_count != '0) && prod_adv;
	assign scaled   = prod_s2 >>> OUT_SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_valid_s2 <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (prod_adv)
				prod_valid_s2 <= pop;
			if (out_free)
				out_valid_q <= prod_valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			prod_s2 <= q_data.tone_sum * $signed({1'b0, q_data.volume_level});
		if (out_free && prod_valid_s2)
			dac_q <= CODE_W'(scaled) + MID_CODE;
	end

	assign sample_out.valid    = out_valid_q;
	assign sample_out.dac_code = dac_q;
endmodule

`default_nettype wire

@@ hdl/two_tone_wavetable_synth_unit.sv @@
// Top level of the two-tone wavetable synthesizer.
`default_nettype none
`include "two_tone_wavetable_synth_unit_assert.svh"

// Two-tone DDS: each sample_in beat advances both phase accumulators, looks
// both phases up in a sine RAM, sums, scales by volume and emits one DAC code
// (2048 = silence). Sustained rate is one beat per clock while sample_out is
// ready and no cfg beat is pending; an input beat passes the sine RAM read,
// the queue, the multiply and the output register on its way to the output
// beat. After reset the sine RAM is loaded from a built-in table, during
// which sample_in is held off. Each step register write is reduced modulo
// the table period by a reciprocal multiply (quotient, then remainder), so
// cfg and sample_in are both held off while the reduction runs; a pending
// cfg beat also holds off sample_in. Writing a zero step clears that tone's phase.
module two_tone_wavetable_synth_unit import tts_pkg::*; #(
	parameter int TABLE_SIZE    = 1024,
	parameter int FRACTION_BITS = 16
) (
	input wire logic  clk,
	input wire logic  arst_n,
	tts_in_if.sink    sample_in,
	tts_out_if.source sample_out,
	tts_cfg_if.sink   cfg
);
	logic               push;
	tts_work_t          push_data;
	logic               pop;
	tts_work_t          pop_data;
	logic [Q_CNT_W-1:0] q_count;
	tts_front_stat_t    front_stat;
	logic               in_beat;
	logic               front_idle;
	logic               q_room;
	logic               step_wr_beat;

	tts_front #(
		.TABLE_SIZE    (TABLE_SIZE),
		.FRACTION_BITS (FRACTION_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_in (sample_in),
		.cfg       (cfg),
		.q_count   (q_count),
		.push      (push),
		.push_data (push_data),
		.stat      (front_stat)
	);

	tts_queue #(
		.WIDTH ($bits(tts_work_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.count     (q_count)
	);

	tts_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_count    (q_count),
		.q_data     (pop_data),
		.pop        (pop),
		.sample_out (sample_out)
	);

	assign in_beat      = sample_in.valid && sample_in.ready;
	assign front_idle   = front_stat.fill_done && !front_stat.red_busy;
	assign q_room       = q_count < Q_CNT_W'(QUEUE_DEPTH);
	assign step_wr_beat = cfg.valid && cfg.ready &&
		(cfg.index == REG_STEP_A || cfg.index == REG_STEP_B);

	`TTS_ASSERT_IMP(a_no_beat_before_ready, clk, arst_n, in_beat, front_idle)
	`TTS_ASSERT_IMP(a_queue_has_room, clk, arst_n, front_stat.s1_valid && !pop, q_room)
	`TTS_ASSERT_NXT(a_step_write_busy, clk, arst_n, step_wr_beat, !cfg.ready && !sample_in.ready)
endmodule

`default_nettype wire

@@ sim/two_tone_wavetable_synth_unit_tb.sv @@
// Self-checking testbench for the two-tone wavetable synthesizer: directed and random ticks.
`timescale 1ns / 100ps

module two_tone_wavetable_synth_unit_tb import tts_pkg::*; ();

	typedef longint unsigned u64_t;

	localparam int   ROM_LEN       = 1024;
	localparam int   FRAC_BITS     = 16;
	localparam int   ITEM_TARGET   = 1300;
	localparam int   SETTLE_CYCLES = 8;
	localparam int   HOLD_CYCLES   = 90;
	localparam int   ANGLE_BITS    = 30;
	localparam int   SERIES_TERMS  = 12;
	localparam u64_t ANG_TWO_PI    = 64'd6746518852;
	localparam u64_t ANG_PI        = 64'd3373259426;
	localparam u64_t ANG_HALF_PI   = 64'd1686629713;
	localparam u64_t SINE_AMP      = 64'd32767;
	localparam int   DAC_MID       = 2048;
	localparam int   DAC_SHIFT     = 17;

	localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_STEP_B + 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED  = '1;
	localparam logic [STEP_W-1:0]    STEP_MAX         = '1;
	localparam logic [STEP_W-1:0]    STEP_ONE_ENTRY   = STEP_W'(1) << FRAC_BITS;
	localparam logic [STEP_W-1:0]    STEP_QUARTER     = STEP_W'(ROM_LEN / 4) << FRAC_BITS;

	class dds_scoreboard;
		logic signed [SAMPLE_W-1:0] sine_lut [ROM_LEN];
		logic [STEP_W-1:0]          step_a;
		logic [STEP_W-1:0]          step_b;
		logic [STEP_W-1:0]          phase_a;
		logic [STEP_W-1:0]          phase_b;
		logic [CODE_W-1:0]          code_q [$];
		int                         errors;

		function new();
			step_a = '0;
			step_b = '0;
			phase_a = '0;
			phase_b = '0;
			errors = 0;
			for (int i = 0; i < ROM_LEN; i++)
				sine_lut[i] = sine_sample(i);
		endfunction

		// Q30 Taylor sine, folded to the first quadrant
		function logic signed [SAMPLE_W-1:0] sine_sample(int idx);
			u64_t ang;
			u64_t x2;
			u64_t term;
			u64_t acc;
			u64_t mag;
			bit   neg;
			ang = (u64_t'(idx) * ANG_TWO_PI) / u64_t'(ROM_LEN);
			neg = (ang >= ANG_PI);
			if (neg)
				ang = ang - ANG_PI;
			if (ang > ANG_HALF_PI)
				ang = ANG_PI - ang;
			x2 = (ang * ang) >> ANGLE_BITS;
			term = ang;
			acc = ang;
			for (int k = 1; k <= SERIES_TERMS; k++) begin
				term = ((term * x2) >> ANGLE_BITS) / u64_t'((2 * k) * (2 * k + 1));
				if (k % 2)
					acc = (acc >= term) ? acc - term : 64'd0;
				else
					acc = acc + term;
			end
			mag = (SINE_AMP * acc) >> ANGLE_BITS;
			if (mag > SINE_AMP)
				mag = SINE_AMP;
			return neg ? -SAMPLE_W'(mag) : SAMPLE_W'(mag);
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [STEP_W-1:0] data);
			case (idx)
				REG_STEP_A: begin
					step_a = data;
					if (data == '0)
						phase_a = '0;
				end
				REG_STEP_B: begin
					step_b = data;
					if (data == '0)
						phase_b = '0;
				end
				default: begin
				end
			endcase
		endfunction

		function void note_tick(logic [VOL_W-1:0] vol);
			int     tone_sum;
			longint prod;
			phase_a = phase_a + step_a;
			phase_b = phase_b + step_b;
			tone_sum = int'(sine_lut[phase_a[STEP_W-1:FRAC_BITS]])
				+ int'(sine_lut[phase_b[STEP_W-1:FRAC_BITS]]);
			prod = longint'(tone_sum) * longint'(vol);
			code_q.push_back(CODE_W'((prod >>> DAC_SHIFT) + DAC_MID));
		endfunction

		function void check_code(logic [CODE_W-1:0] code);
			logic [CODE_W-1:0] want;
			if (code_q.size() == 0) begin
				errors++;
				$display("%0t: dac_code expected none, actual %0d", $time, code);
				return;
			end
			want = code_q.pop_front();
			if (code !== want) begin
				errors++;
				$display("%0t: dac_code expected %0d, actual %0d", $time, want, code);
			end
		endfunction

		function int pending();
			return code_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   src_stall;
	bit   sink_stall;
	bit   long_hold;

	dds_scoreboard sb;

	tts_in_if  in_ch ();
	tts_out_if out_ch ();
	tts_cfg_if cfg_ch ();

	two_tone_wavetable_synth_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_in  (in_ch),
		.sample_out (out_ch),
		.cfg        (cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("two_tone_wavetable_synth_unit_tb: errors");
		$finish;
	end

	function automatic logic [STEP_W-1:0] pick_step();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return STEP_MAX;
			2: return STEP_W'($urandom_range(1, 1 << 16));
			3: return STEP_W'($urandom);
			4: return STEP_W'($urandom_range(1, ROM_LEN - 1)) << FRAC_BITS;
			default: return STEP_W'($urandom_range(1, 1 << 21));
		endcase
	endfunction

	function automatic logic [VOL_W-1:0] pick_volume();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return VOL_W'($urandom);
		endcase
	endfunction

	task automatic send_tick(input logic [VOL_W-1:0] vol);
		int gap;
		gap = src_stall ? $urandom_range(0, 7) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.volume_level <= vol;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_tick(vol);
	endtask

	task automatic stop_ticks();
		@(negedge clk);
		in_ch.valid <= 1'b0;
	endtask

	task automatic settle();
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [STEP_W-1:0] data);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// DAC side: random stalls per beat, one long hold on request
	initial begin : dac_sink
		int gap;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			gap = long_hold ? HOLD_CYCLES : (sink_stall ? $urandom_range(0, 7) : 0);
			long_hold = 1'b0;
			if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			sb.check_code(out_ch.dac_code);
		end
	end

	initial begin
		int sent;
		int burst;
		int phase_no;
		logic [VOL_W-1:0] mixed_vols [8];
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.volume_level = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		src_stall = 1'b0;
		sink_stall = 1'b0;
		long_hold = 1'b0;
		sb = new();
		mixed_vols = '{'1, '0, 12'd1, 12'd2048, '1, '1, 12'hAAA, 12'h555};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// zero steps after reset: silence at any volume
		send_tick('1);
		send_tick('0);
		send_tick(12'd1234);
		stop_ticks();
		settle();

		// one entry per tick against a step that aliases to minus one fraction
		write_reg(REG_STEP_A, STEP_ONE_ENTRY);
		write_reg(REG_STEP_B, STEP_MAX);
		foreach (mixed_vols[i])
			send_tick(mixed_vols[i]);
		stop_ticks();
		settle();

		// unused indexes with zero data must not clear; zero step clears, nonzero keeps
		write_reg(REG_FIRST_UNUSED, '0);
		write_reg(REG_LAST_UNUSED, '0);
		write_reg(REG_STEP_A, '0);
		write_reg(REG_STEP_B, STEP_QUARTER);
		repeat (4) send_tick('1);
		stop_ticks();
		settle();

		// both tones aligned at quarter steps: full-scale swing both ways
		write_reg(REG_STEP_B, '0);
		write_reg(REG_STEP_B, STEP_QUARTER);
		write_reg(REG_STEP_A, STEP_QUARTER);
		repeat (6) send_tick('1);
		stop_ticks();
		settle();

		sent = 0;
		phase_no = 0;
		while (sent < ITEM_TARGET) begin
			phase_no++;
			if ($urandom_range(0, 2) != 0)
				write_reg(REG_STEP_A, pick_step());
			if ($urandom_range(0, 2) != 0)
				write_reg(REG_STEP_B, pick_step());
			if ($urandom_range(0, 3) == 0)
				write_reg(CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)),
					STEP_W'($urandom));
			src_stall = (phase_no % 3 != 1);
			sink_stall = (phase_no % 4 != 2);
			if (phase_no == 3) begin
				src_stall = 1'b0;
				long_hold = 1'b1;
			end
			burst = $urandom_range(80, 140);
			repeat (burst) send_tick(pick_volume());
			sent += burst;
			stop_ticks();
			settle();
		end

		if (sb.errors == 0 && sb.pending() == 0)
			$display("two_tone_wavetable_synth_unit_tb: clean");
		else
			$display("two_tone_wavetable_synth_unit_tb: errors");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/tts_pkg.sv
hdl/tts_in_if.sv
hdl/tts_out_if.sv
hdl/tts_cfg_if.sv
hdl/tts_ram.sv
hdl/tts_queue.sv
hdl/tts_front.sv
hdl/tts_back.sv
hdl/two_tone_wavetable_synth_unit.sv
sim/two_tone_wavetable_synth_unit_tb.sv
